@@ rtl/fbpa_pkg.sv @@
// shared types and constants of the fixed block pool allocator
package fbpa_pkg;

	localparam int CNT_W  = 9;
	localparam int SIZE_W = 16;
	localparam int ADDR_W = 32;
	localparam int IDX_W  = 8;
	localparam int REG_W  = 2;
	localparam int DATA_W = 32;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_EMPTY  = 2'd1;
	localparam logic [1:0] ST_BAD    = 2'd2;
	localparam logic [1:0] ST_MISCFG = 2'd3;

	localparam logic FUNC_GET = 1'b0;
	localparam logic FUNC_PUT = 1'b1;

	localparam logic [REG_W-1:0] REG_BLOCK_COUNT = 2'd0;
	localparam logic [REG_W-1:0] REG_BLOCK_SIZE  = 2'd1;
	localparam logic [REG_W-1:0] REG_BASE_ADDR   = 2'd2;

	typedef struct packed {
		logic [1:0]        status;
		logic [IDX_W-1:0]  granted_index;
		logic [ADDR_W-1:0] granted_addr;
		logic [CNT_W-1:0]  free_count;
	} result_t;

endpackage

@@ rtl/fixed_block_pool_allocator.sv @@
// fixed block pool allocator: lifo free list of block indices in a link store
// a result is registered in the two entry output buffer when its item is accepted
// throughput: one item per cycle while in_ready is high, gets and puts in any mix
// the next free block is prefetched from the link store read port on each get
// after reset and after each write to the count, size or base register the list is
// rebuilt by a sweep of the link store; in_ready stays low until the sweep is done
module fixed_block_pool_allocator
	import fbpa_pkg::*;
#(
	parameter int MAX_BLOCKS = 256,
	parameter int ALIGNMENT = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [REG_W-1:0]  wr_index,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              func,
	input  logic [IDX_W-1:0]  block_index,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status,
	output logic [IDX_W-1:0]  granted_index,
	output logic [ADDR_W-1:0] granted_addr,
	output logic [CNT_W-1:0]  free_count
);

	localparam int LINK_W = $clog2(MAX_BLOCKS + 1);
	localparam int MEM_AW = $clog2(MAX_BLOCKS);
	localparam int REM_W  = $clog2(ALIGNMENT) + 2;
	localparam int STR_W  = $clog2(65536 + ALIGNMENT);
	localparam int PROD_W = LINK_W + STR_W;

	// configuration
	logic [CNT_W-1:0]  count_q;
	logic [SIZE_W-1:0] size_q;
	logic [ADDR_W-1:0] base_q;
	logic              cfg_hit;

	// rebuild control
	logic              restart_q;
	logic              busy_q;
	logic [LINK_W-1:0] clr_q;
	logic              sweep_done;
	logic              sweep_we;
	logic [REM_W-1:0]  size_rem;
	logic [REM_W-1:0]  base_rem;

	// derived configuration
	logic [CNT_W-1:0]  eff_d;
	logic [CNT_W-1:0]  eff_q;
	logic [STR_W-1:0]  stride_d;
	logic [STR_W-1:0]  stride_q;
	logic              pool_ok_q;

	// free list
	logic [LINK_W-1:0] head_q;
	logic [LINK_W-1:0] nxt_q;
	logic              nxt_mem_q;
	logic              nxt_oob_q;
	logic [LINK_W-1:0] nxt_cur;
	logic [CNT_W-1:0]  total_q;

	// link store port
	logic              mem_we;
	logic [MEM_AW-1:0] mem_waddr;
	logic [LINK_W-1:0] mem_wdata;
	logic              mem_re;
	logic [LINK_W-1:0] mem_rdata;

	// item handling
	logic              acc;
	logic              op_get;
	logic              put_bad;
	logic              do_get;
	logic              do_put;
	logic [PROD_W-1:0] prod;
	result_t           res_d;
	result_t           res_out;
	logic              obuf_full;

	assign cfg_hit = wr_en && (wr_index == REG_BLOCK_COUNT || wr_index == REG_BLOCK_SIZE ||
		wr_index == REG_BASE_ADDR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(256);
			size_q  <= SIZE_W'(4);
			base_q  <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_BLOCK_COUNT: count_q <= wr_data[CNT_W-1:0];
				REG_BLOCK_SIZE:  size_q  <= wr_data[SIZE_W-1:0];
				REG_BASE_ADDR:   base_q  <= wr_data[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	fbpa_rem #(.W(SIZE_W), .DIV(ALIGNMENT), .RW(REM_W)) u_size_rem (
		.value (size_q),
		.rem   (size_rem)
	);

	fbpa_rem #(.W(ADDR_W), .DIV(ALIGNMENT), .RW(REM_W)) u_base_rem (
		.value (base_q),
		.rem   (base_rem)
	);

	assign sweep_done = clr_q == LINK_W'(MAX_BLOCKS);
	assign sweep_we   = busy_q && !restart_q && !sweep_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_q <= 1'b1;
			busy_q    <= 1'b1;
			clr_q     <= '0;
		end else begin
			restart_q <= cfg_hit;
			if (restart_q) begin
				busy_q <= 1'b1;
				clr_q  <= '0;
			end else begin
				busy_q <= !sweep_done;
				if (!sweep_done) begin
					clr_q <= clr_q + 1'b1;
				end
			end
		end
	end

	always_comb begin
		eff_d = count_q;
		if (32'(count_q) > 32'(MAX_BLOCKS)) begin
			eff_d = CNT_W'(MAX_BLOCKS);
		end
		stride_d = STR_W'(size_q);
		if (size_rem != '0) begin
			stride_d = STR_W'(size_q) + STR_W'(ALIGNMENT) - STR_W'(size_rem);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_ok_q <= 1'b0;
		end else begin
			pool_ok_q <= count_q != '0 && size_q != '0 && base_rem == '0;
		end
	end

	always_ff @(posedge clk) begin
		eff_q    <= eff_d;
		stride_q <= stride_d;
	end

	// item path
	assign acc     = in_valid && in_ready;
	assign op_get  = func == FUNC_GET;
	assign put_bad = CNT_W'(block_index) >= eff_q || total_q >= eff_q;
	assign do_get  = acc && pool_ok_q && op_get && total_q != '0;
	assign do_put  = acc && pool_ok_q && !op_get && !put_bad;
	assign nxt_cur = nxt_mem_q ? (nxt_oob_q ? '0 : mem_rdata) : nxt_q;
	assign prod    = PROD_W'(head_q) * PROD_W'(stride_q);

	always_comb begin
		res_d = '0;
		if (!pool_ok_q) begin
			res_d.status = ST_MISCFG;
		end else if (op_get) begin
			res_d.free_count = total_q;
			if (total_q == '0) begin
				res_d.status = ST_EMPTY;
			end else begin
				res_d.status        = ST_OK;
				res_d.granted_index = IDX_W'(head_q);
				res_d.granted_addr  = base_q + ADDR_W'(prod);
				res_d.free_count    = total_q - 1'b1;
			end
		end else if (put_bad) begin
			res_d.status     = ST_BAD;
			res_d.free_count = total_q;
		end else begin
			res_d.status     = ST_OK;
			res_d.free_count = total_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			nxt_q     <= LINK_W'(1);
			nxt_mem_q <= 1'b0;
			nxt_oob_q <= 1'b0;
			total_q   <= '0;
		end else if (restart_q) begin
			head_q    <= '0;
			nxt_q     <= LINK_W'(1);
			nxt_mem_q <= 1'b0;
			nxt_oob_q <= 1'b0;
			total_q   <= eff_d;
		end else if (do_get) begin
			head_q    <= nxt_cur;
			nxt_mem_q <= 1'b1;
			nxt_oob_q <= nxt_cur >= LINK_W'(MAX_BLOCKS);
			total_q   <= total_q - 1'b1;
		end else if (do_put) begin
			head_q    <= LINK_W'(block_index);
			nxt_q     <= head_q;
			nxt_mem_q <= 1'b0;
			total_q   <= total_q + 1'b1;
		end
	end

	assign mem_we    = sweep_we || do_put;
	assign mem_waddr = sweep_we ? clr_q[MEM_AW-1:0] : MEM_AW'(block_index);
	assign mem_wdata = sweep_we ? clr_q + 1'b1 : head_q;
	assign mem_re    = do_get;

	fbpa_link_mem #(.DEPTH(MAX_BLOCKS), .AW(MEM_AW), .DW(LINK_W)) u_link_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (nxt_cur[MEM_AW-1:0]),
		.rdata (mem_rdata)
	);

	assign in_ready = !busy_q && !restart_q && !obuf_full;

	fbpa_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (acc),
		.din       (res_d),
		.full      (obuf_full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dout      (res_out)
	);

	assign status        = res_out.status;
	assign granted_index = res_out.granted_index;
	assign granted_addr  = res_out.granted_addr;
	assign free_count    = res_out.free_count;

endmodule

@@ rtl/fbpa_link_mem.sv @@
// link store memory, one write port and one registered read port
module fbpa_link_mem
	import fbpa_pkg::*;
#(
	parameter int DEPTH = 256,
	parameter int AW = 8,
	parameter int DW = 9
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/fbpa_rem.sv @@
// remainder by a power-of-two constant, taken from the low bits of the value
module fbpa_rem
	import fbpa_pkg::*;
#(
	parameter int W = 32,
	parameter int DIV = 4,
	parameter int RW = 4
) (
	input  logic [W-1:0]  value,
	output logic [RW-1:0] rem
);

	logic [W-1:0] low;

	assign low = value & W'(DIV - 1);
	assign rem = low[RW-1:0];

endmodule

@@ rtl/fbpa_obuf.sv @@
// two entry result buffer between the allocator and the output channel
module fbpa_obuf
	import fbpa_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t din,
	output logic    full,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t dout
);

	result_t    ent0_q;
	result_t    ent1_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = cnt_q != 2'd0;
	assign full      = cnt_q == 2'd2;
	assign dout      = ent0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && pop) begin
			if (cnt_q == 2'd1) begin
				ent0_q <= din;
			end else begin
				ent0_q <= ent1_q;
				ent1_q <= din;
			end
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				ent0_q <= din;
			end else begin
				ent1_q <= din;
			end
		end else if (pop) begin
			ent0_q <= ent1_q;
		end
	end

endmodule

@@ rtl/fbpa_checker.sv @@
// port level checks of the fixed block pool allocator and their binding
module fbpa_checker
	import fbpa_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              wr_en,
	input logic [REG_W-1:0]  wr_index,
	input logic [DATA_W-1:0] wr_data,
	input logic              in_valid,
	input logic              in_ready,
	input logic              func,
	input logic [IDX_W-1:0]  block_index,
	input logic              out_valid,
	input logic              out_ready,
	input logic [1:0]        status,
	input logic [IDX_W-1:0]  granted_index,
	input logic [ADDR_W-1:0] granted_addr,
	input logic [CNT_W-1:0]  free_count
);

	// after every accepted item a result is valid in the next cycle
	a_item_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
	else $error("accepted item gave no result");

	// a write to the count, size or base register rebuilds the list and blocks input
	a_cfg_block: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && (wr_index == REG_BLOCK_COUNT || wr_index == REG_BLOCK_SIZE ||
		wr_index == REG_BASE_ADDR) |=> !in_ready)
	else $error("input open during rebuild");

	a_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> granted_index == '0 && granted_addr == '0)
	else $error("grant fields set on a failed item");

	a_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_MISCFG || status == ST_EMPTY) |-> free_count == '0)
	else $error("free count nonzero on empty or misconfigured pool");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(granted_index) && $stable(granted_addr) && $stable(free_count))
	else $error("stalled result changed");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (.*);
